// ===== hdl/tks_pkg.sv =====
// Package for the top-k score selector: beat types, queue entry type and
// fixed widths shared by the front, queue, back and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tks_pkg;

    localparam int SCORE_W = 32;
    localparam int INDEX_W = 10;
    localparam int NTOP_W  = 3;
    localparam int QDEPTH  = 4;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      end_of_vector;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0]        rank_index;
        logic signed [SCORE_W-1:0] rank_score;
        logic                      final_rank;
    } t_out;

    // one classified beat on its way from front to back
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
        logic                      take;
        logic                      last;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== hdl/top_k_score_selector.sv =====
// Top level of the top-k score selector: configuration register, front,
// job queue and back. Depends on tks_pkg, tks_front, tks_queue, tks_back.
// Once the queue ahead of it is drained, the end-of-vector beat passes a queue
// entry, the back's emit phase and the result register before the first rank.
// One beat a cycle mid-vector while busy is low; each end of vector takes the
// back off the queue while it emits its ranks. The 4-entry queue soaks this up
// only while it has room, then busy holds the sender off. busy rises only while
// the queue is full. Results cannot be stalled. Reset (synchronous, active low)
// empties the queue and held list, n_top = 5.
`timescale 1ns / 1ps
`default_nettype none
module top_k_score_selector #(
    parameter int TOP_MAX   = 5,
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire tks_pkg::t_in              i_in,
    input  wire logic                      i_cfg_we,
    input  wire logic [tks_pkg::NTOP_W-1:0] i_cfg_wdata,
    output logic                           o_strobe,
    output tks_pkg::t_out                  o_result
);
    import tks_pkg::*;

    localparam logic [NTOP_W-1:0] NTOP_RESET = NTOP_W'(5);

    logic [NTOP_W-1:0] r_n_top;
    logic              accept;
    logic              push;
    logic              pop;
    t_job              job;
    t_job              head;
    t_q_stat           q_stat;

    // hold n_top; it is only read when an end-of-vector job is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_top <= NTOP_RESET;
        end else if (i_cfg_we) begin
            r_n_top <= i_cfg_wdata;
        end
    end

    // take a beat whenever the queue has room
    assign busy   = q_stat.full;
    assign accept = start && !busy;

    tks_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_job    (job),
        .o_push   (push)
    );

    tks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tks_back #(
        .TOP_MAX (TOP_MAX)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n_top  (r_n_top),
        .i_head   (head),
        .i_stat   (q_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !pop) |=> busy) else $error("busy dropped without a pop");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> accept) else $error("job pushed without accepted beat");
    a_final_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.final_rank) |=> !o_strobe)
        else $error("rank after final rank");

endmodule
`default_nettype wire

// ===== hdl/tks_front.sv =====
// Front of the top-k score selector: accepts beats, counts positions and
// classifies each beat into a queue job. Depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tks_front #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire tks_pkg::t_in    i_in,
    output tks_pkg::t_job        o_job,
    output logic                 o_push
);
    import tks_pkg::*;

    localparam int POS_W = $clog2(MAX_ITEMS + 1);

    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         n_pos;
    logic                     take;
    logic [POS_W+INDEX_W-1:0] pos_ext;

    assign take    = (r_pos < POS_W'(MAX_ITEMS));
    assign pos_ext = {{INDEX_W{1'b0}}, r_pos};

    always_comb begin
        o_job.score = i_in.score;
        o_job.index = pos_ext[INDEX_W-1:0];
        o_job.take  = take;
        o_job.last  = i_in.end_of_vector;
        // drop beats past the limit unless they close the vector
        o_push      = i_accept && (take || i_in.end_of_vector);
    end

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (i_in.end_of_vector) begin
                n_pos = '0;
            end else if (take) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_ITEMS)) else $error("position beyond limit");
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in.end_of_vector) |=> (r_pos == '0))
        else $error("position not restarted after end of vector");
    a_push_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_job.take) |-> o_job.last)
        else $error("untaken beat pushed without end mark");

endmodule
`default_nettype wire

// ===== hdl/tks_queue.sv =====
// Short job queue between front and back of the top-k score selector.
// Register file with head read ahead. Depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tks_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tks_pkg::t_job   i_job,
    input  wire logic            i_pop,
    output tks_pkg::t_job        o_head,
    output tks_pkg::t_q_stat     o_stat
);
    import tks_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(QDEPTH));

    always_comb begin
        n_wr  = i_push ? ((r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + PTR_W'(1)) : r_wr;
        n_rd  = i_pop  ? ((r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + PTR_W'(1)) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty)) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== hdl/tks_back.sv =====
// Back of the top-k score selector: sorted insertion into the held list,
// one job a cycle outside emission, then emission of the ranks. Depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tks_back #(
    parameter int TOP_MAX = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [tks_pkg::NTOP_W-1:0] i_n_top,
    input  wire tks_pkg::t_job             i_head,
    input  wire tks_pkg::t_q_stat          i_stat,
    output logic                           o_pop,
    output logic                           o_strobe,
    output tks_pkg::t_out                  o_result
);
    import tks_pkg::*;

    localparam int CNT_W = $clog2(TOP_MAX + 1);
    localparam int CMP_W = CNT_W + NTOP_W;

    localparam logic PH_TAKE = 1'b0;
    localparam logic PH_EMIT = 1'b1;

    logic                      r_phase;
    logic                      n_phase;
    logic signed [SCORE_W-1:0] r_score [TOP_MAX];
    logic [INDEX_W-1:0]        r_index [TOP_MAX];
    logic signed [SCORE_W-1:0] n_score [TOP_MAX];
    logic [INDEX_W-1:0]        n_index [TOP_MAX];
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          n_fill;
    logic [CNT_W-1:0]          r_left;
    logic [CNT_W-1:0]          n_left;
    logic                      r_strobe;
    logic                      n_strobe;
    t_out                      r_out;
    t_out                      n_out;
    logic [TOP_MAX-1:0]        ge;
    logic [TOP_MAX-1:0][SCORE_W-1:0] ins_score;
    logic [TOP_MAX-1:0][INDEX_W-1:0] ins_index;
    logic [CNT_W-1:0]          fill_ins;
    logic [CMP_W-1:0]          k_ext;
    logic [CMP_W-1:0]          fill_ext;
    logic [CMP_W-1:0]          n_ext;

    // sorted insertion: held entries >= new score stay, the first other slot
    // takes the new score, the rest shift down by one
    always_comb begin
        for (int j = 0; j < TOP_MAX; j++) begin
            ge[j] = (CNT_W'(j) < r_fill) && (r_score[j] >= i_head.score);
        end
        ins_score[0] = ge[0] ? r_score[0] : i_head.score;
        ins_index[0] = ge[0] ? r_index[0] : i_head.index;
        for (int j = 1; j < TOP_MAX; j++) begin
            if (ge[j]) begin
                ins_score[j] = r_score[j];
                ins_index[j] = r_index[j];
            end else if (ge[j-1]) begin
                ins_score[j] = i_head.score;
                ins_index[j] = i_head.index;
            end else begin
                ins_score[j] = r_score[j-1];
                ins_index[j] = r_index[j-1];
            end
        end
        fill_ins = (i_head.take && r_fill < CNT_W'(TOP_MAX)) ? r_fill + CNT_W'(1) : r_fill;
    end

    // ranks to report: n_top clamped to 1..TOP_MAX, then to the fill
    always_comb begin
        k_ext    = (i_n_top == '0) ? CMP_W'(1) : CMP_W'(i_n_top);
        k_ext    = (k_ext > CMP_W'(TOP_MAX)) ? CMP_W'(TOP_MAX) : k_ext;
        fill_ext = CMP_W'(fill_ins);
        n_ext    = (k_ext < fill_ext) ? k_ext : fill_ext;
    end

    always_comb begin
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_out    = r_out;
        o_pop    = 1'b0;
        for (int j = 0; j < TOP_MAX; j++) begin
            n_score[j] = r_score[j];
            n_index[j] = r_index[j];
        end
        unique case (r_phase)
            PH_TAKE: begin
                if (!i_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_head.take) begin
                        for (int j = 0; j < TOP_MAX; j++) begin
                            n_score[j] = ins_score[j];
                            n_index[j] = ins_index[j];
                        end
                    end
                    n_fill = fill_ins;
                    if (i_head.last) begin
                        if (n_ext == '0) begin
                            n_fill = '0;
                        end else begin
                            n_left  = n_ext[CNT_W-1:0];
                            n_phase = PH_EMIT;
                        end
                    end
                end
            end
            PH_EMIT: begin
                // emit the head entry and shift the list up
                n_strobe         = 1'b1;
                n_out.rank_index = r_index[0];
                n_out.rank_score = r_score[0];
                n_out.final_rank = (r_left == CNT_W'(1));
                for (int j = 0; j < TOP_MAX - 1; j++) begin
                    n_score[j] = r_score[j+1];
                    n_index[j] = r_index[j+1];
                end
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_fill  = '0;
                    n_phase = PH_TAKE;
                end
            end
            default: begin
                n_phase = PH_TAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < TOP_MAX; j++) begin
            r_score[j] <= n_score[j];
            r_index[j] <= n_index[j];
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAKE;
            r_fill   <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TOP_MAX)) else $error("fill count out of range");
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT) |-> (r_left != '0 && r_left <= r_fill))
        else $error("emission count inconsistent with fill");
    a_final_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.final_rank) |=> !r_strobe)
        else $error("rank emitted after final rank");
    a_no_pop_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT) |-> !o_pop) else $error("queue popped while emitting");

endmodule
`default_nettype wire
